>>> rtl/core/fltc_pkg.sv
`default_nettype none
package fltc_pkg;

   localparam int unsigned LaneCount = 4;
   localparam int unsigned LaneWidth = 16;
   localparam int unsigned DefaultQueueDepth = 2;
   localparam logic [LaneWidth-1:0] LaneInit = 16'hFFFF;
   localparam logic [1:0] LastIndex = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] check_byte;
      logic [1:0] check_index;
      logic       run_end;
   } rsp_payload_type;

   typedef logic [LaneCount-1:0][7:0] snap_type;

   typedef struct packed {
      logic     push;
      snap_type snap;
   } push_type;

   typedef struct packed {
      logic     avail;
      snap_type snap;
   } head_type;

endpackage
`default_nettype wire

>>> rtl/core/four_lane_subtractive_checksum_top.sv
// Channel   Direction  Ports                        Payload
// request   in         req_valid/req_ready          data_byte[7:0], final_byte
// response  out        rsp_valid/rsp_ready          check_byte[7:0], check_index[1:0], run_end
//
// A request is taken every cycle while the snapshot queue has room; each byte
// updates the lane accumulators in that same cycle (a final byte resets them to 0xFFFF).
// A final byte pushes the four lane high bytes into the queue; the back end
// then sends them as four responses, one per cycle while rsp_ready holds, from its output register.
// Reset is synchronous and active high; it restores all lanes to 0xFFFF.
// A response stall holds the output register and, once the queue fills,
// drops req_ready.
`default_nettype none
module four_lane_subtractive_checksum_top
   import fltc_pkg::*;
#(
   parameter int unsigned QueueDepth = DefaultQueueDepth
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   fltc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push)
   );

   fltc_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   fltc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

>>> rtl/core/fltc_front.sv
`default_nettype none
module fltc_front
   import fltc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic            q_full,
   output push_type             push
);

   logic [LaneCount-1:0][LaneWidth-1:0] lanes_ff, lanes_in;
   logic [1:0]                          phase_ff, phase_in;
   logic [1:0]                          next_phase;
   logic [LaneWidth-1:0]                lane0_last;
   logic                                take;

   assign req_ready  = !q_full;
   assign take       = req_valid && req_ready;
   assign next_phase = phase_ff + 2'd1;
   assign lane0_last = lanes_ff[0] - {8'd0, req_payload.data_byte};

   always_comb begin
      lanes_in = lanes_ff;
      phase_in = phase_ff;
      if (take) begin
         if (req_payload.final_byte) begin
            for (int k = 0; k < LaneCount; k++) lanes_in[k] = LaneInit;
            phase_in = 2'd0;
         end else begin
            for (int k = 0; k < LaneCount; k++) begin
               if (phase_ff == k[1:0]) begin
                  lanes_in[k] = lanes_ff[k] - {req_payload.data_byte, 8'd0};
               end else if (next_phase == k[1:0]) begin
                  lanes_in[k] = lanes_ff[k] - {8'd0, req_payload.data_byte};
               end
            end
            phase_in = next_phase;
         end
      end
   end

   always_comb begin
      push.push = take && req_payload.final_byte;
      push.snap[0] = lane0_last[LaneWidth-1 -: 8];
      for (int k = 1; k < LaneCount; k++) push.snap[k] = lanes_ff[k][LaneWidth-1 -: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LaneCount; k++) lanes_ff[k] <= LaneInit;
         phase_ff <= 2'd0;
      end else begin
         lanes_ff <= lanes_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/fltc_queue.sv
`default_nettype none
module fltc_queue
   import fltc_pkg::*;
#(
   parameter int unsigned QueueDepth = DefaultQueueDepth
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output logic          full,
   output head_type      head
);

   localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QueueDepth - 1);
   localparam logic [CntWidth-1:0] DepthCount = CntWidth'(QueueDepth);

   snap_type               slots_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]    count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == DepthCount);
   assign head.avail = (count_ff != '0);
   assign head.snap  = slots_ff[rd_ptr_ff];
   assign do_push    = push.push && !full;
   assign do_pop     = pop && head.avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push.snap;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push.push && full))
      else $error("push into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCount)
      else $error("queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == DepthCount) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

>>> rtl/core/fltc_back.sv
`default_nettype none
module fltc_back
   import fltc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire head_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type out_ff, out_in;
   logic [1:0]      idx_ff, idx_in;
   logic            load;

   assign load        = head.avail && (!valid_ff || rsp_ready);
   assign pop         = load && (idx_ff == LastIndex);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in           = 1'b1;
         out_in.check_byte  = head.snap[idx_ff];
         out_in.check_index = idx_ff;
         out_in.run_end     = (idx_ff == LastIndex);
         idx_in             = idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      out_ff <= out_in;
   end

   a_index_follows: assert property (@(posedge clock) disable iff (reset)
      load |=> (out_ff.check_index == $past(idx_ff)))
      else $error("result index does not follow counter");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == 2'd0))
      else $error("counter not back at lane 0 after pop");

endmodule
`default_nettype wire
